[sv/tmn_pkg.sv]
// ----------------------------------------------------------------------------
// tmn_pkg
// Types and constants shared by the tridiagonal matrix norm block.
// ----------------------------------------------------------------------------
package tmn_pkg;

  localparam int COMP_W  = 16;
  localparam int SQ_W    = 32;
  localparam int MAG_W   = 24;
  localparam int NORM_W  = 40;
  localparam int SSUM_W  = 64;
  localparam int KIND_W  = 3;

  localparam logic [KIND_W-1:0] K_MAX  = 3'd0;
  localparam logic [KIND_W-1:0] K_ONE  = 3'd1;
  localparam logic [KIND_W-1:0] K_INF  = 3'd2;
  localparam logic [KIND_W-1:0] K_FROB = 3'd3;

  typedef struct packed {
    logic [SQ_W-1:0] sq_sub;
    logic [SQ_W-1:0] sq_diag;
    logic [SQ_W-1:0] sq_sup;
    logic            last;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_UPD,
    S_FROB,
    S_FIN
  } back_state_t;

  function automatic logic [COMP_W-1:0] comp_abs(input logic signed [COMP_W-1:0] v);
    logic [COMP_W-1:0] u;
    u = v;
    return v[COMP_W-1] ? COMP_W'(~u + 1'b1) : u;
  endfunction

endpackage

[sv/tmn_if.sv]
// ----------------------------------------------------------------------------
// tmn_if
// Valid/ready channels: matrix entries in, norm results out.
// ----------------------------------------------------------------------------
interface tmn_in_if import tmn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] sub_re;
  logic signed [COMP_W-1:0] sub_im;
  logic signed [COMP_W-1:0] diag_re;
  logic signed [COMP_W-1:0] diag_im;
  logic signed [COMP_W-1:0] super_re;
  logic signed [COMP_W-1:0] super_im;
  logic                     final_index;

  modport source (output valid, sub_re, sub_im, diag_re, diag_im, super_re, super_im,
                  final_index, input ready);
  modport sink   (input valid, sub_re, sub_im, diag_re, diag_im, super_re, super_im,
                  final_index, output ready);
endinterface

interface tmn_out_if import tmn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NORM_W-1:0] norm_value;
  logic              saturated;

  modport source (output valid, norm_value, saturated, input ready);
  modport sink   (input valid, norm_value, saturated, output ready);
endinterface

[sv/tmn_sqrt.sv]
// ----------------------------------------------------------------------------
// tmn_sqrt
// Bit-serial square root, floor(256*sqrt(v)), one result bit per cycle.
// ----------------------------------------------------------------------------
module tmn_sqrt import tmn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SSUM_W-1:0] operand,
  output logic              done,
  output logic [NORM_W-1:0] root
);

  localparam int REM_W = NORM_W + 4;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [NORM_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [SSUM_W-1:0] sh_r, sh_nxt;
  logic [REM_W-1:0]  rem_t, trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    rem_t    = {rem_r[REM_W-3:0], sh_r[SSUM_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      root_nxt = '0;
      rem_nxt  = '0;
      sh_nxt   = operand;
    end else if (busy_r) begin
      sh_nxt = {sh_r[SSUM_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_nxt  = rem_t - trial;
        root_nxt = {root_r[NORM_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t;
        root_nxt = {root_r[NORM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(NORM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[sv/tmn_front.sv]
// ----------------------------------------------------------------------------
// tmn_front
// Takes entry beats, registers component magnitudes, forms squared moduli.
// ----------------------------------------------------------------------------
module tmn_front import tmn_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  tmn_in_if.sink in_ch,
  output logic   push,
  output entry_t push_entry,
  input  logic   push_ready
);

  logic              stg_valid_r, stg_valid_nxt;
  logic [COMP_W-1:0] a_r [6];
  logic              last_r;
  logic              take;

  assign push      = stg_valid_r && push_ready;
  assign in_ch.ready = !stg_valid_r || push_ready;
  assign take      = in_ch.valid && in_ch.ready;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (take) stg_valid_nxt = 1'b1;
    else if (push) stg_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
    if (take) begin
      a_r[0] <= in_ch.final_index ? '0 : comp_abs(in_ch.sub_re);
      a_r[1] <= in_ch.final_index ? '0 : comp_abs(in_ch.sub_im);
      a_r[2] <= comp_abs(in_ch.diag_re);
      a_r[3] <= comp_abs(in_ch.diag_im);
      a_r[4] <= in_ch.final_index ? '0 : comp_abs(in_ch.super_re);
      a_r[5] <= in_ch.final_index ? '0 : comp_abs(in_ch.super_im);
      last_r <= in_ch.final_index;
    end
  end

  assign push_entry.sq_sub  = SQ_W'(a_r[0]) * SQ_W'(a_r[0]) + SQ_W'(a_r[1]) * SQ_W'(a_r[1]);
  assign push_entry.sq_diag = SQ_W'(a_r[2]) * SQ_W'(a_r[2]) + SQ_W'(a_r[3]) * SQ_W'(a_r[3]);
  assign push_entry.sq_sup  = SQ_W'(a_r[4]) * SQ_W'(a_r[4]) + SQ_W'(a_r[5]) * SQ_W'(a_r[5]);
  assign push_entry.last    = last_r;

endmodule

[sv/tmn_queue.sv]
// ----------------------------------------------------------------------------
// tmn_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module tmn_queue import tmn_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   push_ready,
  input  logic   pop,
  output logic   pop_valid,
  output entry_t pop_entry
);

  entry_t     mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_entry  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(pop && pop_valid)) cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop && pop_valid) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop && pop_valid) rp_r <= !rp_r;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= push_entry;
  end

endmodule

[sv/tmn_back.sv]
// ----------------------------------------------------------------------------
// tmn_back
// Magnitudes through the shared root unit, norm update, result register.
// ----------------------------------------------------------------------------
module tmn_back import tmn_pkg::*; #(
  parameter int MAX_ORDER = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [KIND_W-1:0] kind,
  input  logic              pop_valid,
  input  entry_t            pop_entry,
  output logic              pop,
  tmn_out_if.source         out_ch
);

  localparam int CNT_W = $clog2(MAX_ORDER + 1);

  back_state_t       state_r, state_nxt;
  logic [SQ_W-1:0]   sq_r [3];
  logic              last_r;
  logic [1:0]        idx_r, idx_nxt;
  logic [MAG_W-1:0]  mag_r [3];
  logic [NORM_W-1:0] run_r, run_nxt;
  logic [MAG_W-1:0]  psub_r, psub_nxt, psup_r, psup_nxt;
  logic [SSUM_W-1:0] ssum_r, ssum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [NORM_W-1:0] res_r, res_nxt;
  logic              ov_r, ov_nxt;
  logic [NORM_W-1:0] onorm_r, onorm_nxt;
  logic              osat_r, osat_nxt;
  logic              clr;

  logic              sq_start, sq_done;
  logic [SSUM_W-1:0] sq_op;
  logic [NORM_W-1:0] sq_root;
  logic [NORM_W+1:0] csum;
  logic [SSUM_W:0]   fsum;
  logic [NORM_W-1:0] cand;

  tmn_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .operand (sq_op),
    .done    (sq_done),
    .root    (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      run_r   <= '0;
      psub_r  <= '0;
      psup_r  <= '0;
      ssum_r  <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      run_r   <= clr ? '0 : run_nxt;
      psub_r  <= clr ? '0 : psub_nxt;
      psup_r  <= clr ? '0 : psup_nxt;
      ssum_r  <= clr ? '0 : ssum_nxt;
      cnt_r   <= clr ? '0 : cnt_nxt;
      ovf_r   <= clr ? 1'b0 : ovf_nxt;
    end
    idx_r   <= idx_nxt;
    res_r   <= res_nxt;
    onorm_r <= onorm_nxt;
    osat_r  <= osat_nxt;
    if (pop) begin
      sq_r[0] <= pop_entry.sq_sub;
      sq_r[1] <= pop_entry.sq_diag;
      sq_r[2] <= pop_entry.sq_sup;
      last_r  <= pop_entry.last;
    end
    if (state_r == S_ROOT && sq_done) mag_r[idx_r] <= sq_root[MAG_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    run_nxt   = run_r;
    psub_nxt  = psub_r;
    psup_nxt  = psup_r;
    ssum_nxt  = ssum_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r;
    onorm_nxt = onorm_r;
    osat_nxt  = osat_r;
    clr       = 1'b0;
    pop       = 1'b0;
    sq_start  = 1'b0;
    sq_op     = {{(SSUM_W-SQ_W){1'b0}}, pop_entry.sq_sub};
    csum      = '0;
    fsum      = '0;
    cand      = '0;

    if (ov_r && out_ch.ready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          pop       = 1'b1;
          sq_start  = 1'b1;
          idx_nxt   = 2'd0;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sq_done) begin
          if (idx_r == 2'd2) begin
            state_nxt = S_UPD;
          end else begin
            idx_nxt  = idx_r + 2'd1;
            sq_start = 1'b1;
            sq_op    = {{(SSUM_W-SQ_W){1'b0}}, sq_r[idx_r + 2'd1]};
          end
        end
      end
      S_UPD: begin
        if (cnt_r >= CNT_W'(MAX_ORDER)) ovf_nxt = 1'b1;
        else cnt_nxt = cnt_r + 1'b1;
        case (kind)
          K_MAX: begin
            cand = run_r;
            if (NORM_W'(mag_r[0]) > cand) cand = NORM_W'(mag_r[0]);
            if (NORM_W'(mag_r[1]) > cand) cand = NORM_W'(mag_r[1]);
            if (NORM_W'(mag_r[2]) > cand) cand = NORM_W'(mag_r[2]);
            run_nxt = cand;
          end
          K_ONE, K_INF: begin
            csum = (NORM_W+2)'(kind == K_ONE ? psup_r : psub_r) + (NORM_W+2)'(mag_r[1])
                 + (NORM_W+2)'(kind == K_ONE ? mag_r[0] : mag_r[2]);
            if (csum[NORM_W+1:NORM_W] != 2'b00) begin
              cand    = '1;
              ovf_nxt = 1'b1;
            end else begin
              cand = csum[NORM_W-1:0];
            end
            if (cand > run_r) run_nxt = cand;
          end
          K_FROB: begin
            fsum = (SSUM_W+1)'(ssum_r) + (SSUM_W+1)'(sq_r[0]) + (SSUM_W+1)'(sq_r[1])
                 + (SSUM_W+1)'(sq_r[2]);
            if (fsum[SSUM_W]) begin
              ssum_nxt = '1;
              ovf_nxt  = 1'b1;
            end else begin
              ssum_nxt = fsum[SSUM_W-1:0];
            end
          end
          default: begin
          end
        endcase
        psub_nxt = mag_r[0];
        psup_nxt = mag_r[2];
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (kind == K_FROB) begin
          sq_start  = 1'b1;
          sq_op     = ssum_nxt;
          state_nxt = S_FROB;
        end else begin
          res_nxt   = (kind <= K_INF) ? run_nxt : '0;
          state_nxt = S_FIN;
        end
      end
      S_FROB: begin
        if (sq_done) begin
          res_nxt   = sq_root;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          onorm_nxt = res_r;
          osat_nxt  = ovf_r;
          clr       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.norm_value = onorm_r;
  assign out_ch.saturated  = osat_r;

endmodule

[sv/tridiagonal_matrix_norm_top.sv]
// ----------------------------------------------------------------------------
// tridiagonal_matrix_norm_top
// Streaming norm of a complex tridiagonal matrix, one diagonal index per beat.
// ----------------------------------------------------------------------------
// Each beat carries one diagonal position; the beat with final_index set ends
// the matrix and yields one result beat. A front stage and a two-entry queue
// take beats while the back end works. The back end runs the three entry
// magnitudes through one bit-serial root unit in turn and then updates the
// norm; on a Frobenius matrix the last beat also takes the final root there.
// norm_kind must be written only while idle; the block does not enforce it.
module tridiagonal_matrix_norm_top import tmn_pkg::*; #(
  parameter int MAX_ORDER = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  tmn_in_if.sink            in_ch,
  tmn_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [KIND_W-1:0] cfg_data
);

  logic [KIND_W-1:0] kind_r;
  logic              push, push_ready, pop, pop_valid;
  entry_t            push_entry, pop_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= K_MAX;
    end else if (cfg_we) begin
      kind_r <= cfg_data;
    end
  end

  tmn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  tmn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  tmn_back #(.MAX_ORDER(MAX_ORDER)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .kind      (kind_r),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

[sv/tmn_checker.sv]
// ----------------------------------------------------------------------------
// tmn_checker
// Port-level checks of the norm block, bound to the top level.
// ----------------------------------------------------------------------------
module tmn_checker import tmn_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_final,
  input logic              out_valid,
  input logic              out_ready,
  input logic [NORM_W-1:0] out_norm,
  input logic              out_sat,
  input logic              cfg_we,
  input logic [KIND_W-1:0] cfg_data
);

  logic [KIND_W-1:0] kind_q;
  logic [2:0]        pend_q;
  logic              fin_in, res_out;

  assign fin_in  = in_valid && in_ready && in_final;
  assign res_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_q <= K_MAX;
      pend_q <= '0;
    end else begin
      if (cfg_we) kind_q <= cfg_data;
      if (fin_in && !res_out && pend_q != 3'd7) pend_q <= pend_q + 3'd1;
      else if (!fin_in && res_out && pend_q != 3'd0) pend_q <= pend_q - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_norm) && $stable(out_sat))
    else $error("result beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_q != 3'd0)
    else $error("result without a final beat");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind_q > K_FROB |-> out_norm == '0)
    else $error("unknown norm kind gave nonzero norm");

endmodule

bind tridiagonal_matrix_norm_top tmn_checker u_tmn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_final  (in_ch.final_index),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_norm  (out_ch.norm_value),
  .out_sat   (out_ch.saturated),
  .cfg_we    (cfg_we),
  .cfg_data  (cfg_data)
);

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tridiagonal matrix norm block. Random and
// directed matrices go in over the entry channel under several norm kinds and
// idle patterns. An in-bench model predicts each norm beat, and every result
// beat is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import tmn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ORDER_CAP  = 4096;
  localparam int STALL_LIM  = 20000;
  localparam int SETTLE_CYC = 800;

  typedef struct {
    logic signed [COMP_W-1:0] sub_re, sub_im, diag_re, diag_im, sup_re, sup_im;
    logic                     last;
  } entry_beat_t;

  typedef struct {
    logic [NORM_W-1:0] norm;
    logic              sat;
  } norm_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [KIND_W-1:0] cfg_data;

  tmn_in_if  in_ch ();
  tmn_out_if out_ch ();

  tridiagonal_matrix_norm_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  entry_beat_t pending_entries[$];
  norm_beat_t  expected_norms[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  // model state
  logic [KIND_W-1:0] cur_kind = K_MAX;
  logic [NORM_W-1:0] run_max;
  logic [NORM_W-1:0] prev_sub, prev_sup;
  logic [SSUM_W-1:0] sq_total;
  int                row_count;
  logic              overflowed;

  function automatic logic [NORM_W-1:0] root_q8(logic [SSUM_W-1:0] v);
    logic [79:0] x, t;
    logic [NORM_W-1:0] r;
    x = {v, 16'h0};
    r = '0;
    for (int i = NORM_W - 1; i >= 0; i--) begin
      t = 80'(r | (NORM_W'(1) << i));
      if (t * t <= x) r = r | (NORM_W'(1) << i);
    end
    return r;
  endfunction

  function automatic logic [SSUM_W-1:0] cplx_sq(logic signed [COMP_W-1:0] re,
                                               logic signed [COMP_W-1:0] im);
    longint a, b;
    a = re;
    b = im;
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    return SSUM_W'(a * a + b * b);
  endfunction

  function automatic logic [NORM_W-1:0] sat_add(logic [NORM_W-1:0] a, logic [NORM_W-1:0] b);
    logic [NORM_W:0] s;
    s = a + b;
    if (s[NORM_W]) begin
      overflowed = 1'b1;
      return '1;
    end
    return s[NORM_W-1:0];
  endfunction

  function automatic void sq_add(logic [SSUM_W-1:0] q);
    logic [SSUM_W:0] s;
    s = sq_total + q;
    if (s[SSUM_W]) begin
      overflowed = 1'b1;
      sq_total = '1;
    end else begin
      sq_total = s[SSUM_W-1:0];
    end
  endfunction

  function automatic void clear_matrix();
    run_max = '0;
    prev_sub = '0;
    prev_sup = '0;
    sq_total = '0;
    row_count = 0;
    overflowed = 1'b0;
  endfunction

  function automatic void predict_norm(entry_beat_t e);
    logic [SSUM_W-1:0] q_sub, q_diag, q_sup;
    logic [NORM_W-1:0] m_sub, m_diag, m_sup, cand;
    norm_beat_t r;
    q_sub  = e.last ? '0 : cplx_sq(e.sub_re, e.sub_im);
    q_diag = cplx_sq(e.diag_re, e.diag_im);
    q_sup  = e.last ? '0 : cplx_sq(e.sup_re, e.sup_im);
    m_sub  = root_q8(q_sub);
    m_diag = root_q8(q_diag);
    m_sup  = root_q8(q_sup);
    if (row_count >= ORDER_CAP) overflowed = 1'b1;
    else row_count++;
    case (cur_kind)
      K_MAX: begin
        if (m_sub > run_max) run_max = m_sub;
        if (m_diag > run_max) run_max = m_diag;
        if (m_sup > run_max) run_max = m_sup;
      end
      K_ONE: begin
        cand = sat_add(sat_add(prev_sup, m_diag), m_sub);
        if (cand > run_max) run_max = cand;
      end
      K_INF: begin
        cand = sat_add(sat_add(prev_sub, m_diag), m_sup);
        if (cand > run_max) run_max = cand;
      end
      K_FROB: begin
        sq_add(q_sub);
        sq_add(q_diag);
        sq_add(q_sup);
      end
      default: ;
    endcase
    prev_sub = m_sub;
    prev_sup = m_sup;
    if (e.last) begin
      if (cur_kind <= K_INF) r.norm = run_max;
      else if (cur_kind == K_FROB) r.norm = root_q8(sq_total);
      else r.norm = '0;
      r.sat = overflowed;
      expected_norms.push_back(r);
      clear_matrix();
    end
  endfunction

  task automatic report(string what, logic [NORM_W-1:0] got, logic [NORM_W-1:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // entry driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      automatic logic took = in_ch.valid && in_ch.ready;
      automatic entry_beat_t e;
      if (took) begin
        e.sub_re = in_ch.sub_re;   e.sub_im = in_ch.sub_im;
        e.diag_re = in_ch.diag_re; e.diag_im = in_ch.diag_im;
        e.sup_re = in_ch.super_re; e.sup_im = in_ch.super_im;
        e.last = in_ch.final_index;
        predict_norm(e);
      end
      if (!in_ch.valid || took) begin
        if (pending_entries.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          e = pending_entries.pop_front();
          in_ch.sub_re <= e.sub_re;     in_ch.sub_im <= e.sub_im;
          in_ch.diag_re <= e.diag_re;   in_ch.diag_im <= e.diag_im;
          in_ch.super_re <= e.sup_re;   in_ch.super_im <= e.sup_im;
          in_ch.final_index <= e.last;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      automatic norm_beat_t w;
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_norms.size() == 0) begin
          report("unexpected beat", out_ch.norm_value, '0);
        end else begin
          w = expected_norms.pop_front();
          if (out_ch.norm_value !== w.norm) report("norm_value", out_ch.norm_value, w.norm);
          if (out_ch.saturated !== w.sat)
            report("saturated", NORM_W'(out_ch.saturated), NORM_W'(w.sat));
        end
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIM) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic signed [COMP_W-1:0] pick_comp();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return COMP_W'($urandom_range(3)) - 16'sd1;
      default: return COMP_W'($urandom);
    endcase
  endfunction

  function automatic void push_entry(logic signed [COMP_W-1:0] sr, si, dr, di, ur, ui,
                                     logic last);
    entry_beat_t e;
    e.sub_re = sr; e.sub_im = si; e.diag_re = dr; e.diag_im = di;
    e.sup_re = ur; e.sup_im = ui; e.last = last;
    pending_entries.push_back(e);
  endfunction

  function automatic void push_random_matrix(bit close);
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
    for (int i = 0; i < n; i++)
      push_entry(pick_comp(), pick_comp(), pick_comp(), pick_comp(), pick_comp(),
                 pick_comp(), close && (i == n - 1));
  endfunction

  task automatic drain();
    wait (pending_entries.size() == 0 && !in_ch.valid && expected_norms.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_kind(logic [KIND_W-1:0] k);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= k;
    cur_kind = k;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int kinds[4];
    in_ch.valid = 1'b0;
    in_ch.sub_re = '0; in_ch.sub_im = '0; in_ch.diag_re = '0; in_ch.diag_im = '0;
    in_ch.super_re = '0; in_ch.super_im = '0; in_ch.final_index = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    clear_matrix();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes under every kind, a three-entry and a single-entry matrix
    for (int k = 0; k <= 4; k++) begin
      write_kind(KIND_W'(k));
      push_entry(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
      push_entry(16'sh7fff, -16'sd1, 16'sh7fff, 16'sh7fff, 16'sd0, 16'sh8000, 1'b0);
      push_entry(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd1, 16'sh8000, 16'sh7fff, 1'b1);
      push_entry(16'sh5555, 16'shaaaa, 16'sh8000, 16'sh7fff, 16'shaaaa, 16'sh5555, 1'b1);
      drain();
    end

    kinds = '{K_MAX, K_ONE, K_INF, K_FROB};
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      write_kind((ph == 7) ? KIND_W'(7) : ((ph == 6) ? KIND_W'(4) : KIND_W'(kinds[ph % 4])));
      while (pending_entries.size() < 80) push_random_matrix(1'b1);
      // leave a matrix open so the next kind takes over mid-stream
      if (ph == 2 || ph == 5) push_random_matrix(1'b0);
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_kind(K_FROB);
    push_entry(16'sd1, 16'sd2, 16'sh7fff, 16'sh8000, 16'sd3, 16'sd4, 1'b1);
    drain();

    if (errors == 0 && expected_norms.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
